// ===== hw/rtl/uvst_pkg.sv =====
package uvst_pkg;

    // CORDIC rotation settings, Q2.30 datapath
    localparam int CORDIC_STEPS = 20;
    localparam int AW = 33;
    localparam logic signed [AW-1:0] CORDIC_GAIN = 33'sd652032874;

    // arctangent of 2^-i in phase units (2^32 = one turn)
    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517
    };

    // configuration register indexes
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_STACKS = 2'd1;
    localparam logic [1:0] REG_SLICES = 2'd2;

    // vertex numbers within a cell
    localparam logic [2:0] CORNER_FIRST = 3'd0;
    localparam logic [2:0] CORNER_LAST  = 3'd5;

    // output limits
    localparam logic signed [50:0] POS_MAX  = 51'sd131071;
    localparam logic signed [50:0] POS_MIN  = -51'sd131072;
    localparam logic signed [33:0] NORM_MAX = 34'sd16384;
    localparam logic signed [33:0] NORM_MIN = -34'sd16384;

endpackage

// ===== hw/rtl/uv_sphere_tessellator_top.sv =====
// UV sphere cell tessellator. Each input item is one cell (stack_index in s_tdata[7:0],
// slice_index in s_tdata[15:8]); the block emits the six vertices of the cell's two
// triangles, one per cycle when the output is not stalled, corner 0 to 5, with m_tlast
// on corner 5. A new cell is taken only while the sequencer is idle or issues corner 5
// of the last one, so the single result channel paces intake. Boundary angles come from
// a reciprocal-based phase pipeline and four parallel 20-stage CORDIC pipelines. After
// reset and after every write of stack_count or slice_count a setup pass recomputes the
// per-count reciprocals; s_tready stays low during it.
module uv_sphere_tessellator_top #(
    parameter int MAX_STACKS = 256,
    parameter int MAX_SLICES = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,      // stack_index[7:0], slice_index[15:8]
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[17:0], pos_y[35:18], pos_z[53:36], norm_x[69:54], norm_y[85:70],
    // norm_z[101:86], corner[104:102], zero fill [111:105]
    output logic [111:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_index,
    input  logic [15:0]  cfg_wr_data
);
    import uvst_pkg::*;

    localparam int NST = 5 + CORDIC_STEPS + 1;

    // ---------------- configuration ----------------
    logic [15:0] radius_reg;
    logic [8:0]  stacks_reg, slices_reg;
    logic [8:0]  ns, nl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 16'd4096;
            stacks_reg <= 9'd16;
            slices_reg <= 9'd16;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_RADIUS: radius_reg <= cfg_wr_data;
                REG_STACKS: stacks_reg <= cfg_wr_data[8:0];
                REG_SLICES: slices_reg <= cfg_wr_data[8:0];
                default: ;
            endcase
        end
    end

    // effective counts: zero acts as one, clamp to maximum
    always_comb begin
        ns = stacks_reg;
        if (stacks_reg == 9'd0) ns = 9'd1;
        else if (32'(stacks_reg) > MAX_STACKS) ns = 9'(MAX_STACKS);
        nl = slices_reg;
        if (slices_reg == 9'd0) nl = 9'd1;
        else if (32'(slices_reg) > MAX_SLICES) nl = 9'(MAX_SLICES);
    end

    // ---------------- setup: 2^32 / count, one bit a cycle ----------------
    logic        busy_reg;
    logic [5:0]  step_reg;
    logic [32:0] dq_reg [0:1];
    logic [8:0]  dr_reg [0:1];
    logic [8:0]  nn [0:1];
    logic [9:0]  dt [0:1];
    logic        restart;

    assign nn[0] = ns;
    assign nn[1] = nl;
    assign restart = cfg_wr_en && (cfg_wr_index == REG_STACKS || cfg_wr_index == REG_SLICES);

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            dt[d] = {dr_reg[d], (step_reg == 6'd0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            busy_reg <= 1'b1;
            step_reg <= 6'd0;
            for (int d = 0; d < 2; d++) begin
                dq_reg[d] <= 33'd0;
                dr_reg[d] <= 9'd0;
            end
        end else if (busy_reg) begin
            for (int d = 0; d < 2; d++) begin
                if (dt[d] >= {1'b0, nn[d]}) begin
                    dr_reg[d] <= 9'(dt[d] - {1'b0, nn[d]});
                    dq_reg[d] <= {dq_reg[d][31:0], 1'b1};
                end else begin
                    dr_reg[d] <= dt[d][8:0];
                    dq_reg[d] <= {dq_reg[d][31:0], 1'b0};
                end
            end
            step_reg <= step_reg + 6'd1;
            if (step_reg == 6'd32) busy_reg <= 1'b0;
        end
    end

    // per-count constants: stack uses 2^31 split, slice 2^32 split
    logic [31:0] kq [0:1];
    logic [8:0]  kr [0:1];
    logic [25:0] km [0:1];
    logic [7:0]  kh [0:1];
    logic [9:0]  r31_sum;

    always_comb begin
        r31_sum = (dq_reg[0][0] ? {1'b0, nn[0]} : 10'd0) + {1'b0, dr_reg[0]};
        kq[0] = dq_reg[0][32:1];
        kr[0] = r31_sum[9:1];
        kq[1] = dq_reg[1][31:0];
        kr[1] = dr_reg[1];
        for (int d = 0; d < 2; d++) begin
            km[d] = dq_reg[d][32:7];
            kh[d] = nn[d][8:1];
        end
    end

    // ---------------- front pipeline control ----------------
    logic v_reg [0:NST-1];
    logic fv, take, en;
    logic seq_v_reg;
    logic [2:0] corner_reg;
    logic e_en;

    assign fv   = v_reg[NST-1];
    assign take = fv && (!seq_v_reg || (corner_reg == CORNER_LAST && e_en));
    assign en   = !fv || take;
    assign s_tready = en && !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= s_tvalid && s_tready;
            for (int i = 1; i < NST; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    // ---------------- phase pipeline (lanes: stack k, k+1, slice m, m+1) ----------------
    logic [7:0]  si, li;
    logic [8:0]  k_reg  [0:3];
    logic [16:0] x1_reg [0:3], x2_reg [0:3], x3_reg [0:3];
    logic [31:0] h1_reg [0:3], h2_reg [0:3], h3_reg [0:3];
    logic [16:0] qa2_reg [0:3], qa3_reg [0:3];
    logic [25:0] t3_reg [0:3];
    logic [31:0] ph_reg [0:3];
    logic [25:0] rr [0:3];
    logic [16:0] qf [0:3];

    // clamp indices to count-1
    always_comb begin
        si = s_tdata[7:0];
        li = s_tdata[15:8];
        if ({1'b0, si} > ns - 9'd1) si = 8'(ns - 9'd1);
        if ({1'b0, li} > nl - 9'd1) li = 8'(nl - 9'd1);
        for (int l = 0; l < 4; l++) begin
            rr[l] = 26'(x3_reg[l]) - t3_reg[l];
            qf[l] = qa3_reg[l] + 17'(rr[l] >= 26'(nn[l/2]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg[0] <= {1'b0, si};
            k_reg[1] <= {1'b0, si} + 9'd1;
            k_reg[2] <= {1'b0, li};
            k_reg[3] <= {1'b0, li} + 9'd1;
            for (int l = 0; l < 4; l++) begin
                // integer part and remainder term
                x1_reg[l] <= 17'(k_reg[l]) * 17'(kr[l/2]) + 17'(kh[l/2]);
                h1_reg[l] <= 32'(41'(k_reg[l]) * 41'(kq[l/2]));
                // remainder quotient estimate by reciprocal
                qa2_reg[l] <= 17'((43'(x1_reg[l]) * 43'(km[l/2])) >> 25);
                x2_reg[l]  <= x1_reg[l];
                h2_reg[l]  <= h1_reg[l];
                t3_reg[l]  <= 26'(qa2_reg[l]) * 26'(nn[l/2]);
                qa3_reg[l] <= qa2_reg[l];
                x3_reg[l]  <= x2_reg[l];
                h3_reg[l]  <= h2_reg[l];
                // correct estimate, offset latitude by a quarter turn
                ph_reg[l] <= h3_reg[l] + 32'(qf[l]) - ((l < 2) ? 32'h40000000 : 32'd0);
            end
        end
    end

    // ---------------- CORDIC pipelines ----------------
    logic signed [AW-1:0] cx_reg [0:CORDIC_STEPS-1][0:3];
    logic signed [AW-1:0] cy_reg [0:CORDIC_STEPS-1][0:3];
    logic signed [AW-1:0] cz_reg [0:CORDIC_STEPS-1][0:3];
    logic [1:0]           cq_reg [0:CORDIC_STEPS-1][0:3];
    logic signed [AW-1:0] cx_next [0:CORDIC_STEPS-1][0:3];
    logic signed [AW-1:0] cy_next [0:CORDIC_STEPS-1][0:3];
    logic signed [AW-1:0] cz_next [0:CORDIC_STEPS-1][0:3];
    logic [1:0]           cq_next [0:CORDIC_STEPS-1][0:3];
    logic signed [AW-1:0] sc_reg [0:3], ss_reg [0:3];

    always_comb begin
        logic signed [AW-1:0] xi, yi, zi, at;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            for (int l = 0; l < 4; l++) begin
                if (i == 0) begin
                    xi = CORDIC_GAIN;
                    yi = '0;
                    zi = $signed({3'b000, ph_reg[l][29:0]});
                    cq_next[i][l] = ph_reg[l][31:30];
                end else begin
                    xi = cx_reg[i-1][l];
                    yi = cy_reg[i-1][l];
                    zi = cz_reg[i-1][l];
                    cq_next[i][l] = cq_reg[i-1][l];
                end
                at = $signed({1'b0, ATAN_TURNS[i]});
                if (zi >= 0) begin
                    cx_next[i][l] = xi - (yi >>> i);
                    cy_next[i][l] = yi + (xi >>> i);
                    cz_next[i][l] = zi - at;
                end else begin
                    cx_next[i][l] = xi + (yi >>> i);
                    cy_next[i][l] = yi - (xi >>> i);
                    cz_next[i][l] = zi + at;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                for (int l = 0; l < 4; l++) begin
                    cx_reg[i][l] <= cx_next[i][l];
                    cy_reg[i][l] <= cy_next[i][l];
                    cz_reg[i][l] <= cz_next[i][l];
                    cq_reg[i][l] <= cq_next[i][l];
                end
            end
            // map back to the quadrant
            for (int l = 0; l < 4; l++) begin
                case (cq_reg[CORDIC_STEPS-1][l])
                    2'd0: begin
                        sc_reg[l] <= cx_reg[CORDIC_STEPS-1][l];
                        ss_reg[l] <= cy_reg[CORDIC_STEPS-1][l];
                    end
                    2'd1: begin
                        sc_reg[l] <= -cy_reg[CORDIC_STEPS-1][l];
                        ss_reg[l] <= cx_reg[CORDIC_STEPS-1][l];
                    end
                    2'd2: begin
                        sc_reg[l] <= -cx_reg[CORDIC_STEPS-1][l];
                        ss_reg[l] <= -cy_reg[CORDIC_STEPS-1][l];
                    end
                    default: begin
                        sc_reg[l] <= cy_reg[CORDIC_STEPS-1][l];
                        ss_reg[l] <= -cx_reg[CORDIC_STEPS-1][l];
                    end
                endcase
            end
        end
    end

    // ---------------- corner sequencer ----------------
    logic signed [AW-1:0] lat_c_reg [0:1], lat_s_reg [0:1];
    logic signed [AW-1:0] lon_c_reg [0:1], lon_s_reg [0:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_v_reg  <= 1'b0;
            corner_reg <= CORNER_FIRST;
        end else if (take) begin
            seq_v_reg  <= 1'b1;
            corner_reg <= CORNER_FIRST;
        end else if (seq_v_reg && e_en) begin
            if (corner_reg == CORNER_LAST) seq_v_reg <= 1'b0;
            else corner_reg <= corner_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int j = 0; j < 2; j++) begin
                lat_c_reg[j] <= sc_reg[j];
                lat_s_reg[j] <= ss_reg[j];
                lon_c_reg[j] <= sc_reg[2+j];
                lon_s_reg[j] <= ss_reg[2+j];
            end
        end
    end

    // ---------------- vertex pipeline ----------------
    logic                 lon_sel, lat_sel;
    logic                 e1_v_reg, e2_v_reg, e3_v_reg, m_tvalid_reg;
    logic [2:0]           e1_c_reg, e2_c_reg, e3_c_reg, o_c_reg;
    logic signed [65:0]   px_reg, py_reg;
    logic signed [AW-1:0] pz_reg;
    logic signed [AW-1:0] n_reg [0:2];
    logic signed [AW-1:0] nv [0:2];
    logic signed [65:0]   rpx, rpy;
    logic signed [50:0]   pr_reg [0:2];
    logic signed [50:0]   pv [0:2];
    logic signed [33:0]   mv [0:2];
    logic signed [15:0]   norm_reg [0:2], o_norm_reg [0:2];
    logic signed [17:0]   o_pos_reg [0:2];
    logic signed [17:0]   pos_sat [0:2];

    assign e_en = !m_tvalid_reg || m_tready;
    assign lon_sel = (corner_reg == 3'd2) || (corner_reg == 3'd4) || (corner_reg == 3'd5);
    assign lat_sel = (corner_reg == 3'd1) || (corner_reg == 3'd3) || (corner_reg == 3'd5);

    // round products back to Q2.30, saturate results
    always_comb begin
        rpx = (px_reg + 66'sd536870912) >>> 30;
        rpy = (py_reg + 66'sd536870912) >>> 30;
        nv[0] = rpx[AW-1:0];
        nv[1] = rpy[AW-1:0];
        nv[2] = pz_reg;
        for (int a = 0; a < 3; a++) begin
            mv[a] = (34'(n_reg[a]) + 34'sd32768) >>> 16;
            pv[a] = (pr_reg[a] + 51'sd536870912) >>> 30;
            if (pv[a] > POS_MAX) pos_sat[a] = 18'sd131071;
            else if (pv[a] < POS_MIN) pos_sat[a] = -18'sd131072;
            else pos_sat[a] = pv[a][17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_v_reg     <= 1'b0;
            e2_v_reg     <= 1'b0;
            e3_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (e_en) begin
            e1_v_reg     <= seq_v_reg;
            e2_v_reg     <= e1_v_reg;
            e3_v_reg     <= e2_v_reg;
            m_tvalid_reg <= e3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_en) begin
            // normal products
            px_reg   <= lon_c_reg[lon_sel] * lat_c_reg[lat_sel];
            py_reg   <= lon_s_reg[lon_sel] * lat_c_reg[lat_sel];
            pz_reg   <= lat_s_reg[lat_sel];
            e1_c_reg <= corner_reg;
            for (int a = 0; a < 3; a++) n_reg[a] <= nv[a];
            e2_c_reg <= e1_c_reg;
            // scale by radius, finish normals
            for (int a = 0; a < 3; a++) begin
                pr_reg[a] <= 51'(n_reg[a]) * 51'($signed({1'b0, radius_reg}));
                if (mv[a] > NORM_MAX) norm_reg[a] <= 16'sd16384;
                else if (mv[a] < NORM_MIN) norm_reg[a] <= -16'sd16384;
                else norm_reg[a] <= mv[a][15:0];
            end
            e3_c_reg <= e2_c_reg;
            // output register
            for (int a = 0; a < 3; a++) begin
                o_pos_reg[a]  <= pos_sat[a];
                o_norm_reg[a] <= norm_reg[a];
            end
            o_c_reg <= e3_c_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = (o_c_reg == CORNER_LAST);
    assign m_tdata  = {7'd0, o_c_reg,
                       o_norm_reg[2], o_norm_reg[1], o_norm_reg[0],
                       o_pos_reg[2], o_pos_reg[1], o_pos_reg[0]};

endmodule
